// ===== sv/hvd_pkg.sv =====
`timescale 1ns / 1ps
// Package: shared types, constants and tables of the haversine distance pipeline.
package hvd_pkg;

   // Field widths
   localparam int LAT_W    = 28;
   localparam int LON_W    = 29;
   localparam int RADIUS_W = 16;
   localparam int DIST_W   = 34;

   // Internal formats: angles, sines and roots are Q30
   localparam int ANG_W  = 31;
   localparam int CORD_W = 34;
   localparam int ROOT_W = 31;

   // Four angle lanes travel through the front end and the rotation CORDIC
   localparam int NLANES     = 4;
   localparam int LANE_COS_A = 0;
   localparam int LANE_COS_B = 1;
   localparam int LANE_HLAT  = 2;
   localparam int LANE_HLON  = 3;

   // CORDIC depth (12..32), two iterations per register stage
   localparam int CORDIC_ITERATIONS = 24;
   localparam int CORDIC_PER_STAGE  = 2;
   localparam int CORDIC_STAGES     =
      (CORDIC_ITERATIONS + CORDIC_PER_STAGE - 1) / CORDIC_PER_STAGE;

   localparam logic [30:0] ONE_Q30      = 31'h4000_0000;
   localparam logic [30:0] HALF_PI_Q30  = 31'd1686629713;
   localparam logic [31:0] PI_Q30       = 32'd3373259426;
   localparam logic [30:0] KINV_Q30     = 31'd652032874;
   localparam logic [29:0] PI_Q28       = 30'd843314856;
   localparam logic [15:0] RADIUS_RESET = 16'd6371;

   typedef logic signed [CORD_W-1:0] cord_type;
   typedef logic [ANG_W-1:0]         angle_type;
   typedef logic [ROOT_W-1:0]        root_type;

   // atan(2^-i) in Q30, truncated
   localparam cord_type ATAN_Q30 [32] = '{
      34'sh3243F6A8, 34'sh1DAC6705, 34'sh0FADBAFC, 34'sh07F56EA6,
      34'sh03FEAB76, 34'sh01FFD55B, 34'sh00FFFAAA, 34'sh007FFF55,
      34'sh003FFFEA, 34'sh001FFFFD, 34'sh000FFFFF, 34'sh0007FFFF,
      34'sh0003FFFF, 34'sh0001FFFF, 34'sh0000FFFF, 34'sh00007FFF,
      34'sh00003FFF, 34'sh00001FFF, 34'sh00000FFF, 34'sh000007FF,
      34'sh000003FF, 34'sh000001FF, 34'sh000000FF, 34'sh0000007F,
      34'sh0000003F, 34'sh0000001F, 34'sh0000000F, 34'sh00000008,
      34'sh00000004, 34'sh00000002, 34'sh00000001, 34'sh00000000
   };

endpackage

// ===== sv/haversine_distance.sv =====
`timescale 1ns / 1ps
// Top level: great-circle distance pipeline with its radius register.
//
//   channel   direction  handshake               word
//   req_*     in         start & !busy           lat_a, lon_a, lat_b, lon_b (deg, Q20)
//   rsp_*     out        rsp_strobe, one cycle   distance_km (km, Q16)
//   csr_*     in         csr_valid & csr_ready   sphere radius, whole km
//
// One word is taken every cycle and carried through the two CORDIC chains, the
// reciprocal multiply for the division by 45 and the 31-step square roots,
// all pipelined.
// Synchronous reset clears every valid bit and loads the radius with 6371;
// busy and csr_ready are held off only while reset is high.
// The receiver cannot stall, so the pipeline never holds: each result word is
// shown for exactly one cycle in the order its inputs arrived.
module haversine_distance (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [hvd_pkg::LAT_W-1:0]    req_lat_a,
   input  logic signed [hvd_pkg::LON_W-1:0]    req_lon_a,
   input  logic signed [hvd_pkg::LAT_W-1:0]    req_lat_b,
   input  logic signed [hvd_pkg::LON_W-1:0]    req_lon_b,
   output logic                                rsp_strobe,
   output logic [hvd_pkg::DIST_W-1:0]          rsp_distance_km,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hvd_pkg::RADIUS_W-1:0]        csr_data
);

   // Radius register
   logic [hvd_pkg::RADIUS_W-1:0] radius_ff;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= hvd_pkg::RADIUS_RESET;
      end else if (csr_valid && csr_ready) begin
         radius_ff <= csr_data;
      end
   end

   assign busy = reset;

   // Front end
   logic               fr_valid;
   hvd_pkg::angle_type fr_angle [hvd_pkg::NLANES];

   hvd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_lat_a  (req_lat_a),
      .in_lon_a  (req_lon_a),
      .in_lat_b  (req_lat_b),
      .in_lon_b  (req_lon_b),
      .out_valid (fr_valid),
      .out_angle (fr_angle)
   );

   // Sines and cosines
   logic              rot_valid;
   hvd_pkg::cord_type rot_cos [hvd_pkg::NLANES];
   hvd_pkg::cord_type rot_sin [hvd_pkg::NLANES];

   hvd_cordic_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_angle  (fr_angle),
      .out_valid (rot_valid),
      .out_cos   (rot_cos),
      .out_sin   (rot_sin)
   );

   // Haversine term and roots
   logic              cmb_valid;
   hvd_pkg::root_type cmb_sa, cmb_sb;

   hvd_combine u_combine (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rot_valid),
      .in_cos    (rot_cos),
      .in_sin    (rot_sin),
      .out_valid (cmb_valid),
      .out_sa    (cmb_sa),
      .out_sb    (cmb_sb)
   );

   // Central angle and distance
   hvd_cordic_vec u_vec (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (cmb_valid),
      .in_x         (cmb_sb),
      .in_y         (cmb_sa),
      .radius       (radius_ff),
      .out_valid    (rsp_strobe),
      .out_distance (rsp_distance_km)
   );

   // A zero radius must give a zero distance
   a_zero_radius: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (radius_ff == '0) && $stable(radius_ff) |-> rsp_distance_km == '0)
      else $error("nonzero distance with zero radius");

endmodule

// ===== sv/hvd_front.sv =====
`timescale 1ns / 1ps
// Front end: clamp, differences, degrees to radians and half-longitude folding.
module hvd_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic signed [hvd_pkg::LAT_W-1:0]      in_lat_a,
   input  logic signed [hvd_pkg::LON_W-1:0]      in_lon_a,
   input  logic signed [hvd_pkg::LAT_W-1:0]      in_lat_b,
   input  logic signed [hvd_pkg::LON_W-1:0]      in_lon_b,
   output logic                                  out_valid,
   output hvd_pkg::angle_type                    out_angle [hvd_pkg::NLANES]
);

   // Division by 45 by reciprocal multiplication; dividends stay below 2^38
   localparam logic [38:0] RECIP_45 = 39'd390937467654;  // ceil(2^44 / 45)
   localparam logic [19:0] RECIP_LO = RECIP_45[19:0];
   localparam logic [18:0] RECIP_HI = RECIP_45[38:20];
   localparam logic [59:0] ROUND_FULL = 60'd23592960;  // 45 * 2^19
   localparam logic [59:0] ROUND_HALF = 60'd47185920;  // 45 * 2^20
   localparam logic signed [29:0] LAT_LIMIT = 30'sd94371840;
   localparam logic signed [29:0] LON_LIMIT = 30'sd188743680;

   function automatic logic signed [29:0] clamp_deg(input logic signed [29:0] v,
                                                    input logic signed [29:0] lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic logic [28:0] abs_deg(input logic signed [29:0] v);
      logic signed [29:0] m;
      m = (v < 0) ? -v : v;
      return m[28:0];
   endfunction

   // Stage 0: clamped coordinates
   logic                 v0_ff;
   logic signed [29:0]   lat_a_ff, lon_a_ff, lat_b_ff, lon_b_ff;

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else v0_ff <= in_valid;
      lat_a_ff <= clamp_deg(30'(in_lat_a), LAT_LIMIT);
      lon_a_ff <= clamp_deg(30'(in_lon_a), LON_LIMIT);
      lat_b_ff <= clamp_deg(30'(in_lat_b), LAT_LIMIT);
      lon_b_ff <= clamp_deg(30'(in_lon_b), LON_LIMIT);
   end

   // Stage 1: magnitudes of the latitudes and of the differences
   logic        v1_ff;
   logic [28:0] mag_ff [hvd_pkg::NLANES];

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= v0_ff;
      mag_ff[hvd_pkg::LANE_COS_A] <= abs_deg(lat_a_ff);
      mag_ff[hvd_pkg::LANE_COS_B] <= abs_deg(lat_b_ff);
      mag_ff[hvd_pkg::LANE_HLAT]  <= abs_deg(lat_b_ff - lat_a_ff);
      mag_ff[hvd_pkg::LANE_HLON]  <= abs_deg(lon_b_ff - lon_a_ff);
   end

   // Stage 2: times pi
   logic        v2_ff;
   logic [58:0] prod_ff [hvd_pkg::NLANES];

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      for (int l = 0; l < hvd_pkg::NLANES; l++) begin
         prod_ff[l] <= 59'(mag_ff[l]) * 59'(hvd_pkg::PI_Q28);
      end
   end

   // Stage 3: rounding offset and power-of-two part of the divisor
   logic        v3_ff;
   logic [37:0] dvd_ff [hvd_pkg::NLANES];

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      dvd_ff[hvd_pkg::LANE_COS_A] <=
         38'((60'(prod_ff[hvd_pkg::LANE_COS_A]) + ROUND_FULL) >> 20);
      dvd_ff[hvd_pkg::LANE_COS_B] <=
         38'((60'(prod_ff[hvd_pkg::LANE_COS_B]) + ROUND_FULL) >> 20);
      dvd_ff[hvd_pkg::LANE_HLAT] <=
         38'((60'(prod_ff[hvd_pkg::LANE_HLAT]) + ROUND_HALF) >> 21);
      dvd_ff[hvd_pkg::LANE_HLON] <=
         38'((60'(prod_ff[hvd_pkg::LANE_HLON]) + ROUND_HALF) >> 21);
   end

   // Stage 4: 19 x 20 and 19 x 19 bit partial products of dividend and reciprocal
   logic        v4_ff;
   logic [38:0] pll_ff [hvd_pkg::NLANES];
   logic [37:0] plh_ff [hvd_pkg::NLANES];
   logic [38:0] phl_ff [hvd_pkg::NLANES];
   logic [37:0] phh_ff [hvd_pkg::NLANES];

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
      for (int l = 0; l < hvd_pkg::NLANES; l++) begin
         pll_ff[l] <= 39'(dvd_ff[l][18:0]) * 39'(RECIP_LO);
         plh_ff[l] <= 38'(dvd_ff[l][18:0]) * 38'(RECIP_HI);
         phl_ff[l] <= 39'(dvd_ff[l][37:19]) * 39'(RECIP_LO);
         phh_ff[l] <= 38'(dvd_ff[l][37:19]) * 38'(RECIP_HI);
      end
   end

   // Stage 5: the two middle partials, aligned at 2^19
   logic        v5_ff;
   logic [38:0] pll5_ff [hvd_pkg::NLANES];
   logic [39:0] pmid_ff [hvd_pkg::NLANES];
   logic [37:0] phh5_ff [hvd_pkg::NLANES];

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else v5_ff <= v4_ff;
      for (int l = 0; l < hvd_pkg::NLANES; l++) begin
         pll5_ff[l] <= pll_ff[l];
         pmid_ff[l] <= 40'({plh_ff[l], 1'b0}) + 40'(phl_ff[l]);
         phh5_ff[l] <= phh_ff[l];
      end
   end

   // Stage 6: full product, quotient is the product over 2^44
   logic        v6_ff;
   logic [31:0] quo_ff [hvd_pkg::NLANES];

   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else v6_ff <= v5_ff;
      for (int l = 0; l < hvd_pkg::NLANES; l++) begin
         quo_ff[l] <= 32'((77'(pll5_ff[l]) + (77'(pmid_ff[l]) << 19)
                           + (77'(phh5_ff[l]) << 39)) >> 44);
      end
   end

   // Final stage: clamp the half angles, fold the half longitude into [0, pi/2]
   logic        q_valid;
   logic [31:0] q [hvd_pkg::NLANES];
   logic [31:0] hlon_cap;
   logic [31:0] hlon_fold;

   always_comb begin
      q_valid = v6_ff;
      for (int l = 0; l < hvd_pkg::NLANES; l++) begin
         q[l] = quo_ff[l];
      end
      hlon_cap  = (q[hvd_pkg::LANE_HLON] > hvd_pkg::PI_Q30) ? hvd_pkg::PI_Q30
                                                           : q[hvd_pkg::LANE_HLON];
      hlon_fold = (hlon_cap > 32'(hvd_pkg::HALF_PI_Q30)) ? hvd_pkg::PI_Q30 - hlon_cap
                                                         : hlon_cap;
   end

   logic               ov_ff;
   hvd_pkg::angle_type ang_ff [hvd_pkg::NLANES];

   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else ov_ff <= q_valid;
      ang_ff[hvd_pkg::LANE_COS_A] <= q[hvd_pkg::LANE_COS_A][30:0];
      ang_ff[hvd_pkg::LANE_COS_B] <= q[hvd_pkg::LANE_COS_B][30:0];
      ang_ff[hvd_pkg::LANE_HLAT]  <= (q[hvd_pkg::LANE_HLAT] > 32'(hvd_pkg::HALF_PI_Q30))
                                     ? hvd_pkg::HALF_PI_Q30 : q[hvd_pkg::LANE_HLAT][30:0];
      ang_ff[hvd_pkg::LANE_HLON]  <= hlon_fold[30:0];
   end

   assign out_valid = ov_ff;
   assign out_angle = ang_ff;

   // Half angles must reach the CORDIC inside its convergence range
   a_half_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_angle[hvd_pkg::LANE_HLAT] <= hvd_pkg::HALF_PI_Q30) &&
                    (out_angle[hvd_pkg::LANE_HLON] <= hvd_pkg::HALF_PI_Q30))
      else $error("half angle beyond pi/2");

endmodule

// ===== sv/hvd_cordic_rot.sv =====
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC, four lanes, gives cosine and sine in Q30.
module hvd_cordic_rot (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  hvd_pkg::angle_type in_angle [hvd_pkg::NLANES],
   output logic               out_valid,
   output hvd_pkg::cord_type  out_cos [hvd_pkg::NLANES],
   output hvd_pkg::cord_type  out_sin [hvd_pkg::NLANES]
);

   localparam int LAST = hvd_pkg::CORDIC_STAGES - 1;

   logic              v_ff [hvd_pkg::CORDIC_STAGES];
   hvd_pkg::cord_type x_ff [hvd_pkg::CORDIC_STAGES][hvd_pkg::NLANES];
   hvd_pkg::cord_type y_ff [hvd_pkg::CORDIC_STAGES][hvd_pkg::NLANES];
   hvd_pkg::cord_type z_ff [hvd_pkg::CORDIC_STAGES][hvd_pkg::NLANES];

   for (genvar s = 0; s < hvd_pkg::CORDIC_STAGES; s++) begin : g_stage
      logic              src_v;
      hvd_pkg::cord_type src_x [hvd_pkg::NLANES];
      hvd_pkg::cord_type src_y [hvd_pkg::NLANES];
      hvd_pkg::cord_type src_z [hvd_pkg::NLANES];
      hvd_pkg::cord_type x_in  [hvd_pkg::NLANES];
      hvd_pkg::cord_type y_in  [hvd_pkg::NLANES];
      hvd_pkg::cord_type z_in  [hvd_pkg::NLANES];

      // Start vector: gain inverse on x, angle in z
      if (s == 0) begin : g_first
         always_comb begin
            src_v = in_valid;
            for (int l = 0; l < hvd_pkg::NLANES; l++) begin
               src_x[l] = hvd_pkg::cord_type'({3'b000, hvd_pkg::KINV_Q30});
               src_y[l] = '0;
               src_z[l] = hvd_pkg::cord_type'({3'b000, in_angle[l]});
            end
         end
      end else begin : g_next
         always_comb begin
            src_v = v_ff[s-1];
            src_x = x_ff[s-1];
            src_y = y_ff[s-1];
            src_z = z_ff[s-1];
         end
      end

      // Micro-rotations of this stage; steps past the iteration count pass through
      always_comb begin
         hvd_pkg::cord_type xv, yv, zv, dx, dy;
         xv = '0; yv = '0; zv = '0; dx = '0; dy = '0;
         for (int l = 0; l < hvd_pkg::NLANES; l++) begin
            xv = src_x[l];
            yv = src_y[l];
            zv = src_z[l];
            for (int j = 0; j < hvd_pkg::CORDIC_PER_STAGE; j++) begin
               if (s * hvd_pkg::CORDIC_PER_STAGE + j < hvd_pkg::CORDIC_ITERATIONS) begin
                  dx = yv >>> (s * hvd_pkg::CORDIC_PER_STAGE + j);
                  dy = xv >>> (s * hvd_pkg::CORDIC_PER_STAGE + j);
                  if (!zv[hvd_pkg::CORD_W-1]) begin
                     xv = xv - dx;
                     yv = yv + dy;
                     zv = zv - hvd_pkg::ATAN_Q30[5'(s * hvd_pkg::CORDIC_PER_STAGE + j)];
                  end else begin
                     xv = xv + dx;
                     yv = yv - dy;
                     zv = zv + hvd_pkg::ATAN_Q30[5'(s * hvd_pkg::CORDIC_PER_STAGE + j)];
                  end
               end
            end
            x_in[l] = xv;
            y_in[l] = yv;
            z_in[l] = zv;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[s] <= 1'b0;
         else v_ff[s] <= src_v;
         x_ff[s] <= x_in;
         y_ff[s] <= y_in;
         z_ff[s] <= z_in;
      end
   end

   assign out_valid = v_ff[LAST];
   assign out_cos   = x_ff[LAST];
   assign out_sin   = y_ff[LAST];

endmodule

// ===== sv/hvd_combine.sv =====
`timescale 1ns / 1ps
// Haversine term a from sines and cosines, then the two square roots.
module hvd_combine (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  hvd_pkg::cord_type  in_cos [hvd_pkg::NLANES],
   input  hvd_pkg::cord_type  in_sin [hvd_pkg::NLANES],
   output logic               out_valid,
   output hvd_pkg::root_type  out_sa,
   output hvd_pkg::root_type  out_sb
);

   // Digit-recurrence square root, four result bits a stage
   localparam int SQ_STEPS     = hvd_pkg::ROOT_W;
   localparam int SQ_PER_STAGE = 4;
   localparam int SQ_STAGES    = (SQ_STEPS + SQ_PER_STAGE - 1) / SQ_PER_STAGE;
   localparam int SQ_LAST      = SQ_STAGES - 1;
   localparam logic [61:0] HALF_LSB = 62'd1 << 29;

   function automatic logic [30:0] clamp_cos(input hvd_pkg::cord_type c);
      if (c[hvd_pkg::CORD_W-1]) return '0;
      if (c > hvd_pkg::cord_type'({3'b000, hvd_pkg::ONE_Q30})) return hvd_pkg::ONE_Q30;
      return c[30:0];
   endfunction

   function automatic logic [30:0] clamp_mag(input hvd_pkg::cord_type s);
      hvd_pkg::cord_type m;
      m = s[hvd_pkg::CORD_W-1] ? -s : s;
      if (m > hvd_pkg::cord_type'({3'b000, hvd_pkg::ONE_Q30})) return hvd_pkg::ONE_Q30;
      return m[30:0];
   endfunction

   function automatic logic [30:0] round_q30(input logic [61:0] p);
      return 31'((p + HALF_LSB) >> 30);
   endfunction

   // Stage 0: clamped cosines and sine magnitudes
   logic        k0_v_ff;
   logic [30:0] ca_ff, cb_ff, ml_ff, mo_ff;

   always_ff @(posedge clock) begin
      if (reset) k0_v_ff <= 1'b0;
      else k0_v_ff <= in_valid;
      ca_ff <= clamp_cos(in_cos[hvd_pkg::LANE_COS_A]);
      cb_ff <= clamp_cos(in_cos[hvd_pkg::LANE_COS_B]);
      ml_ff <= clamp_mag(in_sin[hvd_pkg::LANE_HLAT]);
      mo_ff <= clamp_mag(in_sin[hvd_pkg::LANE_HLON]);
   end

   // Stage 1: cos*cos and the two squares
   logic        k1_v_ff;
   logic [61:0] pt_ff, pl_ff, po_ff;

   always_ff @(posedge clock) begin
      if (reset) k1_v_ff <= 1'b0;
      else k1_v_ff <= k0_v_ff;
      pt_ff <= 62'(ca_ff) * 62'(cb_ff);
      pl_ff <= 62'(ml_ff) * 62'(ml_ff);
      po_ff <= 62'(mo_ff) * 62'(mo_ff);
   end

   // Stage 2: back to Q30
   logic        k2_v_ff;
   logic [30:0] t_ff, sl_ff, so_ff;

   always_ff @(posedge clock) begin
      if (reset) k2_v_ff <= 1'b0;
      else k2_v_ff <= k1_v_ff;
      t_ff  <= round_q30(pt_ff);
      sl_ff <= round_q30(pl_ff);
      so_ff <= round_q30(po_ff);
   end

   // Stage 3: cos*cos*sin^2(dlon/2)
   logic        k3_v_ff;
   logic [61:0] pts_ff;
   logic [30:0] sl3_ff;

   always_ff @(posedge clock) begin
      if (reset) k3_v_ff <= 1'b0;
      else k3_v_ff <= k2_v_ff;
      pts_ff <= 62'(t_ff) * 62'(so_ff);
      sl3_ff <= sl_ff;
   end

   // Stage 4: a, clamped to one
   logic        k4_v_ff;
   logic [30:0] a_ff;
   logic [31:0] a_sum;

   assign a_sum = 32'(sl3_ff) + 32'(round_q30(pts_ff));

   always_ff @(posedge clock) begin
      if (reset) k4_v_ff <= 1'b0;
      else k4_v_ff <= k3_v_ff;
      a_ff <= (a_sum > 32'(hvd_pkg::ONE_Q30)) ? hvd_pkg::ONE_Q30 : a_sum[30:0];
   end

   // Stage 5: radicands a * 2^30 and (1 - a) * 2^30
   logic        k5_v_ff;
   logic [61:0] rad_a_ff, rad_b_ff;

   always_ff @(posedge clock) begin
      if (reset) k5_v_ff <= 1'b0;
      else k5_v_ff <= k4_v_ff;
      rad_a_ff <= 62'({a_ff, 30'b0});
      rad_b_ff <= 62'({31'(hvd_pkg::ONE_Q30 - a_ff), 30'b0});
   end

   // Square-root stages, lane 0 for sqrt(a), lane 1 for sqrt(1 - a)
   logic              sv_ff   [SQ_STAGES];
   logic [61:0]       srad_ff [SQ_STAGES][2];
   logic [34:0]       srem_ff [SQ_STAGES][2];
   hvd_pkg::root_type sroot_ff[SQ_STAGES][2];

   for (genvar s = 0; s < SQ_STAGES; s++) begin : g_sqrt
      logic              src_v;
      logic [61:0]       src_rad  [2];
      logic [34:0]       src_rem  [2];
      hvd_pkg::root_type src_root [2];
      logic [61:0]       srad_in  [2];
      logic [34:0]       srem_in  [2];
      hvd_pkg::root_type sroot_in [2];

      if (s == 0) begin : g_first
         always_comb begin
            src_v       = k5_v_ff;
            src_rad[0]  = rad_a_ff;
            src_rad[1]  = rad_b_ff;
            src_rem[0]  = '0;
            src_rem[1]  = '0;
            src_root[0] = '0;
            src_root[1] = '0;
         end
      end else begin : g_next
         always_comb begin
            src_v    = sv_ff[s-1];
            src_rad  = srad_ff[s-1];
            src_rem  = srem_ff[s-1];
            src_root = sroot_ff[s-1];
         end
      end

      always_comb begin
         logic [61:0]       radv;
         logic [34:0]       remv, rem2, trial;
         hvd_pkg::root_type rootv;
         radv = '0; remv = '0; rem2 = '0; trial = '0; rootv = '0;
         for (int l = 0; l < 2; l++) begin
            radv  = src_rad[l];
            remv  = src_rem[l];
            rootv = src_root[l];
            for (int j = 0; j < SQ_PER_STAGE; j++) begin
               if (s * SQ_PER_STAGE + j < SQ_STEPS) begin
                  rem2  = {remv[32:0], radv[61:60]};
                  radv  = {radv[59:0], 2'b00};
                  trial = {2'b00, rootv, 2'b01};
                  if (rem2 >= trial) begin
                     remv  = rem2 - trial;
                     rootv = {rootv[hvd_pkg::ROOT_W-2:0], 1'b1};
                  end else begin
                     remv  = rem2;
                     rootv = {rootv[hvd_pkg::ROOT_W-2:0], 1'b0};
                  end
               end
            end
            srad_in[l]  = radv;
            srem_in[l]  = remv;
            sroot_in[l] = rootv;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) sv_ff[s] <= 1'b0;
         else sv_ff[s] <= src_v;
         srad_ff[s]  <= srad_in;
         srem_ff[s]  <= srem_in;
         sroot_ff[s] <= sroot_in;
      end
   end

   assign out_valid = sv_ff[SQ_LAST];
   assign out_sa    = sroot_ff[SQ_LAST][0];
   assign out_sb    = sroot_ff[SQ_LAST][1];

   // a never exceeds one, so neither root can exceed one in Q30
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (out_sa <= hvd_pkg::ONE_Q30) && (out_sb <= hvd_pkg::ONE_Q30))
      else $error("square root beyond one");

   // The root only grows by shifting in bits: the top bit stays clear until the end
   a_root_early: assert property (@(posedge clock) disable iff (reset)
      sv_ff[0] |-> !sroot_ff[0][0][hvd_pkg::ROOT_W-1] && !sroot_ff[0][1][hvd_pkg::ROOT_W-1])
      else $error("square root overflow in first stage");

endmodule

// ===== sv/hvd_cordic_vec.sv =====
`timescale 1ns / 1ps
// Pipelined vectoring-mode CORDIC for the central angle, then scaling by the radius.
module hvd_cordic_vec (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  hvd_pkg::root_type             in_x,
   input  hvd_pkg::root_type             in_y,
   input  logic [hvd_pkg::RADIUS_W-1:0]  radius,
   output logic                          out_valid,
   output logic [hvd_pkg::DIST_W-1:0]    out_distance
);

   localparam int LAST = hvd_pkg::CORDIC_STAGES - 1;
   localparam int MUL_W = hvd_pkg::RADIUS_W + hvd_pkg::ANG_W;
   localparam logic [MUL_W:0] ROUND_OFS = (MUL_W + 1)'(4096);

   logic              v_ff [hvd_pkg::CORDIC_STAGES];
   hvd_pkg::cord_type x_ff [hvd_pkg::CORDIC_STAGES];
   hvd_pkg::cord_type y_ff [hvd_pkg::CORDIC_STAGES];
   hvd_pkg::cord_type z_ff [hvd_pkg::CORDIC_STAGES];

   for (genvar s = 0; s < hvd_pkg::CORDIC_STAGES; s++) begin : g_stage
      logic              src_v;
      hvd_pkg::cord_type src_x, src_y, src_z;
      hvd_pkg::cord_type x_in, y_in, z_in;

      if (s == 0) begin : g_first
         always_comb begin
            src_v = in_valid;
            src_x = hvd_pkg::cord_type'({3'b000, in_x});
            src_y = hvd_pkg::cord_type'({3'b000, in_y});
            src_z = '0;
         end
      end else begin : g_next
         always_comb begin
            src_v = v_ff[s-1];
            src_x = x_ff[s-1];
            src_y = y_ff[s-1];
            src_z = z_ff[s-1];
         end
      end

      // Drive y toward zero, accumulate the angle in z
      always_comb begin
         hvd_pkg::cord_type xv, yv, zv, dx, dy;
         xv = src_x;
         yv = src_y;
         zv = src_z;
         dx = '0;
         dy = '0;
         for (int j = 0; j < hvd_pkg::CORDIC_PER_STAGE; j++) begin
            if (s * hvd_pkg::CORDIC_PER_STAGE + j < hvd_pkg::CORDIC_ITERATIONS) begin
               dx = yv >>> (s * hvd_pkg::CORDIC_PER_STAGE + j);
               dy = xv >>> (s * hvd_pkg::CORDIC_PER_STAGE + j);
               if (yv > 0) begin
                  xv = xv + dx;
                  yv = yv - dy;
                  zv = zv + hvd_pkg::ATAN_Q30[5'(s * hvd_pkg::CORDIC_PER_STAGE + j)];
               end else begin
                  xv = xv - dx;
                  yv = yv + dy;
                  zv = zv - hvd_pkg::ATAN_Q30[5'(s * hvd_pkg::CORDIC_PER_STAGE + j)];
               end
            end
         end
         x_in = xv;
         y_in = yv;
         z_in = zv;
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[s] <= 1'b0;
         else v_ff[s] <= src_v;
         x_ff[s] <= x_in;
         y_ff[s] <= y_in;
         z_ff[s] <= z_in;
      end
   end

   // Negative angle reads as zero, then R * angle
   hvd_pkg::angle_type ang;
   logic               mv_ff;
   logic [MUL_W-1:0]   mp_ff;

   assign ang = z_ff[LAST][hvd_pkg::CORD_W-1] ? '0 : z_ff[LAST][hvd_pkg::ANG_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) mv_ff <= 1'b0;
      else mv_ff <= v_ff[LAST];
      mp_ff <= MUL_W'(radius) * MUL_W'(ang);
   end

   // Q30 angle doubled, to Q16 km, rounded half up
   logic                       dv_ff;
   logic [hvd_pkg::DIST_W-1:0] dist_ff;

   always_ff @(posedge clock) begin
      if (reset) dv_ff <= 1'b0;
      else dv_ff <= mv_ff;
      dist_ff <= hvd_pkg::DIST_W'(((MUL_W + 1)'(mp_ff) + ROUND_OFS) >> 13);
   end

   assign out_valid    = dv_ff;
   assign out_distance = dist_ff;

   // Both start coordinates are non-negative, so x only grows
   a_x_positive: assert property (@(posedge clock) disable iff (reset)
      v_ff[LAST] |-> !x_ff[LAST][hvd_pkg::CORD_W-1])
      else $error("vectoring x went negative");

endmodule
